// ===== rtl/spv_pkg.sv =====
// shared types and constants for the spin polyhedron volume pipeline
// no dependencies
package spv_pkg;

  localparam int VOL_WIDTH  = 32;
  localparam int GUARD_BITS = 12;
  localparam int MUL_CHUNK  = 32;
  localparam int FIELD_W    = 32;

  typedef struct packed {
    logic signed [FIELD_W-1:0] s1_x;
    logic signed [FIELD_W-1:0] s1_y;
    logic signed [FIELD_W-1:0] s1_z;
    logic signed [FIELD_W-1:0] s2_x;
    logic signed [FIELD_W-1:0] s2_y;
    logic signed [FIELD_W-1:0] s2_z;
    logic signed [FIELD_W-1:0] s3_x;
    logic signed [FIELD_W-1:0] s3_y;
    logic signed [FIELD_W-1:0] s3_z;
    logic signed [FIELD_W-1:0] s4_x;
    logic signed [FIELD_W-1:0] s4_y;
    logic signed [FIELD_W-1:0] s4_z;
  } spv_in_t;

  typedef struct packed {
    logic signed [VOL_WIDTH-1:0] volume;
    logic                        degenerate;
    logic                        saturated;
  } spv_out_t;

  typedef struct packed {
    logic valid;
    logic degen;
  } spv_ctl_t;

endpackage

// ===== rtl/spv_tprod.sv =====
// triple product front end: cross products, dot products, magnitudes
// depends on spv_pkg
module spv_tprod #(
  parameter int CW = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               req,
  input  spv_pkg::spv_in_t   in_item,
  output logic [3*CW:0]      m1,
  output logic [3*CW:0]      m2,
  output logic [3*CW:0]      m3,
  output logic [3*CW:0]      n1,
  output logic [3*CW:0]      n2,
  output logic [3*CW:0]      n3,
  output logic [3*CW:0]      absw,
  output spv_pkg::spv_ctl_t  ctl
);

  localparam int XCW = 2 * CW + 1;
  localparam int TW  = 3 * CW + 2;
  localparam int MW  = 3 * CW + 1;
  localparam int XA [3] = '{1, 2, 1};
  localparam int XB [3] = '{2, 3, 3};
  localparam int LV [4] = '{0, 1, 0, 0};
  localparam int XV [4] = '{0, 1, 1, 2};

  function automatic logic signed [XCW-1:0] xprod(input logic signed [CW-1:0] a,
      input logic signed [CW-1:0] b, input logic signed [CW-1:0] c,
      input logic signed [CW-1:0] d);
    logic signed [2*CW-1:0] p0;
    logic signed [2*CW-1:0] p1;
    p0 = a * b;
    p1 = c * d;
    return XCW'(p0) - XCW'(p1);
  endfunction

  function automatic logic [MW-1:0] mag(input logic signed [TW-1:0] v);
    logic signed [TW-1:0] t;
    t = v[TW-1] ? -v : v;
    return t[MW-1:0];
  endfunction

  logic signed [CW-1:0]  s_in [4][3];
  logic signed [CW-1:0]  s1_q [4][3];
  logic signed [CW-1:0]  s2_q [2][3];
  logic signed [XCW-1:0] x_q  [3][3];
  logic signed [XCW-1:0] pl_q [4][3];
  logic signed [XCW-1:0] ph_q [4][3];
  logic signed [TW-1:0]  w_q  [4];
  logic [4:0]            v_q;
  logic                  deg;

  always_comb begin
    s_in[0][0] = CW'(in_item.s1_x);
    s_in[0][1] = CW'(in_item.s1_y);
    s_in[0][2] = CW'(in_item.s1_z);
    s_in[1][0] = CW'(in_item.s2_x);
    s_in[1][1] = CW'(in_item.s2_y);
    s_in[1][2] = CW'(in_item.s2_z);
    s_in[2][0] = CW'(in_item.s3_x);
    s_in[2][1] = CW'(in_item.s3_y);
    s_in[2][2] = CW'(in_item.s3_z);
    s_in[3][0] = CW'(in_item.s4_x);
    s_in[3][1] = CW'(in_item.s4_y);
    s_in[3][2] = CW'(in_item.s4_z);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[3:0], req};
    end
    s1_q <= s_in;
    for (int i = 0; i < 2; i++) begin
      s2_q[i] <= s1_q[i];
    end
    for (int k = 0; k < 3; k++) begin
      x_q[k][0] <= xprod(s1_q[XA[k]][1], s1_q[XB[k]][2], s1_q[XA[k]][2], s1_q[XB[k]][1]);
      x_q[k][1] <= xprod(s1_q[XA[k]][2], s1_q[XB[k]][0], s1_q[XA[k]][0], s1_q[XB[k]][2]);
      x_q[k][2] <= xprod(s1_q[XA[k]][0], s1_q[XB[k]][1], s1_q[XA[k]][1], s1_q[XB[k]][0]);
    end
    for (int d = 0; d < 4; d++) begin
      for (int c = 0; c < 3; c++) begin
        pl_q[d][c] <= s2_q[LV[d]][c] * $signed({1'b0, x_q[XV[d]][c][CW-1:0]});
        ph_q[d][c] <= s2_q[LV[d]][c] * $signed(x_q[XV[d]][c][XCW-1:CW]);
      end
    end
    for (int d = 0; d < 4; d++) begin
      w_q[d] <= ((TW'(ph_q[d][0]) <<< CW) + TW'(pl_q[d][0]))
              + ((TW'(ph_q[d][1]) <<< CW) + TW'(pl_q[d][1]))
              + ((TW'(ph_q[d][2]) <<< CW) + TW'(pl_q[d][2]));
    end
    m1   <= mag(w_q[1]);
    m2   <= mag(w_q[2]);
    m3   <= mag(w_q[3]);
    n1   <= mag(w_q[1] + w_q[0]);
    n2   <= mag(w_q[2] - w_q[0]);
    n3   <= mag(w_q[3] + w_q[0]);
    absw <= mag(w_q[0]);
    deg  <= (w_q[0] == '0);
  end

  assign ctl = '{valid: v_q[4], degen: deg};

endmodule

// ===== rtl/spv_mul.sv =====
// two-lane wide unsigned multiplier, one 32x32 partial product per stage
// depends on spv_pkg
module spv_mul #(
  parameter int AW  = 64,
  parameter int BW  = 64,
  parameter int SBW = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              vin,
  input  logic [AW-1:0]     a0,
  input  logic [BW-1:0]     b0,
  input  logic [AW-1:0]     a1,
  input  logic [BW-1:0]     b1,
  input  logic [SBW-1:0]    sbin,
  output logic              vout,
  output logic [AW+BW-1:0]  p0,
  output logic [AW+BW-1:0]  p1,
  output logic [SBW-1:0]    sbout
);

  localparam int CH = spv_pkg::MUL_CHUNK;
  localparam int NA = (AW + CH - 1) / CH;
  localparam int NB = (BW + CH - 1) / CH;
  localparam int NS = NA * NB;
  localparam int PW = AW + BW;
  localparam int EW = CH * (NA + NB);

  logic [NA*CH-1:0] a0_q  [NS-1];
  logic [NA*CH-1:0] a1_q  [NS-1];
  logic [NB*CH-1:0] b0_q  [NS-1];
  logic [NB*CH-1:0] b1_q  [NS-1];
  logic [PW-1:0]    acc0_q [NS];
  logic [PW-1:0]    acc1_q [NS];
  logic [SBW-1:0]   sb_q  [NS];
  logic [NS-1:0]    v_q;

  for (genvar k = 0; k < NS; k++) begin : g_stage
    localparam int I = k / NB;
    localparam int J = k % NB;
    logic [NA*CH-1:0] a0_in, a1_in;
    logic [NB*CH-1:0] b0_in, b1_in;
    logic [PW-1:0]    acc0_in, acc1_in;
    logic [SBW-1:0]   sb_in;
    logic             v_in;
    logic [2*CH-1:0]  pp0, pp1;
    logic [EW-1:0]    ext0, ext1;

    if (k == 0) begin : g_first
      assign a0_in   = (NA*CH)'(a0);
      assign a1_in   = (NA*CH)'(a1);
      assign b0_in   = (NB*CH)'(b0);
      assign b1_in   = (NB*CH)'(b1);
      assign acc0_in = '0;
      assign acc1_in = '0;
      assign sb_in   = sbin;
      assign v_in    = vin;
    end else begin : g_next
      assign a0_in   = a0_q[k-1];
      assign a1_in   = a1_q[k-1];
      assign b0_in   = b0_q[k-1];
      assign b1_in   = b1_q[k-1];
      assign acc0_in = acc0_q[k-1];
      assign acc1_in = acc1_q[k-1];
      assign sb_in   = sb_q[k-1];
      assign v_in    = v_q[k-1];
    end

    assign pp0  = a0_in[I*CH +: CH] * b0_in[J*CH +: CH];
    assign pp1  = a1_in[I*CH +: CH] * b1_in[J*CH +: CH];
    assign ext0 = EW'(pp0) << (CH * (I + J));
    assign ext1 = EW'(pp1) << (CH * (I + J));

    always_ff @(posedge clk) begin
      if (rst) begin
        v_q[k] <= 1'b0;
      end else begin
        v_q[k] <= v_in;
      end
      acc0_q[k] <= acc0_in + ext0[PW-1:0];
      acc1_q[k] <= acc1_in + ext1[PW-1:0];
      sb_q[k]   <= sb_in;
    end

    if (k < NS - 1) begin : g_carry
      always_ff @(posedge clk) begin
        a0_q[k] <= a0_in;
        a1_q[k] <= a1_in;
        b0_q[k] <= b0_in;
        b1_q[k] <= b1_in;
      end
    end
  end

  assign vout  = v_q[NS-1];
  assign p0    = acc0_q[NS-1];
  assign p1    = acc1_q[NS-1];
  assign sbout = sb_q[NS-1];

endmodule

// ===== rtl/spv_sqrt2.sv =====
// paired integer square root, one result bit per pipeline stage
// depends on nothing beyond its parameters
module spv_sqrt2 #(
  parameter int RW  = 64,
  parameter int SBW = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              vin,
  input  logic [RW-1:0]     x0,
  input  logic [RW-1:0]     x1,
  input  logic [SBW-1:0]    sbin,
  output logic              vout,
  output logic [RW/2-1:0]   r0,
  output logic [RW/2-1:0]   r1,
  output logic [SBW-1:0]    sbout
);

  localparam int N = RW / 2;

  logic [RW-1:0]  rem0_q  [N-1];
  logic [RW-1:0]  rem1_q  [N-1];
  logic [N-1:0]   root0_q [N];
  logic [N-1:0]   root1_q [N];
  logic [SBW-1:0] sb_q    [N];
  logic [N-1:0]   v_q;

  for (genvar s = 0; s < N; s++) begin : g_stage
    localparam int K = N - 1 - s;
    logic [RW-1:0]  rem0_in, rem1_in, d0, d1;
    logic [N-1:0]   root0_in, root1_in;
    logic [SBW-1:0] sb_in;
    logic           v_in, ge0, ge1;

    if (s == 0) begin : g_first
      assign rem0_in  = x0;
      assign rem1_in  = x1;
      assign root0_in = '0;
      assign root1_in = '0;
      assign sb_in    = sbin;
      assign v_in     = vin;
    end else begin : g_next
      assign rem0_in  = rem0_q[s-1];
      assign rem1_in  = rem1_q[s-1];
      assign root0_in = root0_q[s-1];
      assign root1_in = root1_q[s-1];
      assign sb_in    = sb_q[s-1];
      assign v_in     = v_q[s-1];
    end

    assign d0  = (RW'(root0_in) << (K + 1)) | (RW'(1'b1) << (2 * K));
    assign d1  = (RW'(root1_in) << (K + 1)) | (RW'(1'b1) << (2 * K));
    assign ge0 = rem0_in >= d0;
    assign ge1 = rem1_in >= d1;

    always_ff @(posedge clk) begin
      if (rst) begin
        v_q[s] <= 1'b0;
      end else begin
        v_q[s] <= v_in;
      end
      root0_q[s] <= root0_in | (N'(ge0) << K);
      root1_q[s] <= root1_in | (N'(ge1) << K);
      sb_q[s]    <= sb_in;
    end

    if (s < N - 1) begin : g_rem
      always_ff @(posedge clk) begin
        rem0_q[s] <= ge0 ? rem0_in - d0 : rem0_in;
        rem1_q[s] <= ge1 ? rem1_in - d1 : rem1_in;
      end
    end
  end

  assign vout  = v_q[N-1];
  assign r0    = root0_q[N-1];
  assign r1    = root1_q[N-1];
  assign sbout = sb_q[N-1];

endmodule

// ===== rtl/spv_div.sv =====
// difference of roots, rounded division by 3*|w123|, saturation and result register
// depends on spv_pkg
module spv_div #(
  parameter int RTW = 64,
  parameter int MW  = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  spv_pkg::spv_ctl_t  ctl_in,
  input  logic [RTW-1:0]     ra,
  input  logic [RTW-1:0]     rb,
  input  logic [MW-1:0]      absw,
  output logic               done,
  output spv_pkg::spv_out_t  result
);

  localparam int VW    = spv_pkg::VOL_WIDTH;
  localparam int G     = spv_pkg::GUARD_BITS;
  localparam int QB    = VW + 1;
  localparam int DENW  = MW + 2 + G;
  localparam int BASEW = (RTW + 1 > DENW) ? RTW + 1 : DENW;
  localparam int XW    = BASEW + QB + 2;

  logic [RTW-1:0]    ra_a, rb_a;
  logic [MW-1:0]     aw_a;
  spv_pkg::spv_ctl_t ctl_a;

  logic [RTW-1:0]    dm;
  logic              dneg;
  logic [XW-1:0]     den;
  logic [XW-1:0]     num_b, dvs_b;
  logic              dneg_b;
  spv_pkg::spv_ctl_t ctl_b;

  logic [XW-1:0]     rem_q  [QB+1];
  logic [XW-1:0]     dvs_q  [QB];
  logic [QB-1:0]     quo_q  [QB+1];
  logic              dneg_q [QB+1];
  logic              ovf_q  [QB+1];
  spv_pkg::spv_ctl_t ctl_q  [QB+1];

  always_comb begin
    dneg = rb_a > ra_a;
    dm   = dneg ? rb_a - ra_a : ra_a - rb_a;
    den  = ((XW'(aw_a) << 1) + XW'(aw_a)) << G;
  end

  always_ff @(posedge clk) begin
    ra_a   <= ra;
    rb_a   <= rb;
    aw_a   <= absw;
    ctl_a.degen <= ctl_in.degen;
    num_b  <= (XW'(dm) << 1) + den;
    dvs_b  <= den << 1;
    dneg_b <= dneg;
    ctl_b.degen <= ctl_a.degen;
    rem_q[0]  <= num_b;
    dvs_q[0]  <= dvs_b;
    quo_q[0]  <= '0;
    dneg_q[0] <= dneg_b;
    ovf_q[0]  <= num_b >= (dvs_b << QB);
    ctl_q[0].degen <= ctl_b.degen;
    if (rst) begin
      ctl_a.valid    <= 1'b0;
      ctl_b.valid    <= 1'b0;
      ctl_q[0].valid <= 1'b0;
    end else begin
      ctl_a.valid    <= ctl_in.valid;
      ctl_b.valid    <= ctl_a.valid;
      ctl_q[0].valid <= ctl_b.valid;
    end
  end

  for (genvar t = 0; t < QB; t++) begin : g_step
    localparam int J = QB - 1 - t;
    logic [XW-1:0] sh;
    logic          ge;

    assign sh = dvs_q[t] << J;
    assign ge = rem_q[t] >= sh;

    always_ff @(posedge clk) begin
      rem_q[t+1]  <= ge ? rem_q[t] - sh : rem_q[t];
      quo_q[t+1]  <= quo_q[t] | (QB'(ge) << J);
      dneg_q[t+1] <= dneg_q[t];
      ovf_q[t+1]  <= ovf_q[t];
      ctl_q[t+1].degen <= ctl_q[t].degen;
      if (rst) begin
        ctl_q[t+1].valid <= 1'b0;
      end else begin
        ctl_q[t+1].valid <= ctl_q[t].valid;
      end
    end

    if (t < QB - 1) begin : g_carry
      always_ff @(posedge clk) begin
        dvs_q[t+1] <= dvs_q[t];
      end
    end
  end

  logic [QB-1:0] mag, limit, clip;
  logic          neg, sat;

  always_comb begin
    mag   = quo_q[QB];
    neg   = dneg_q[QB] && (mag != '0);
    limit = (QB'(1'b1) << (VW - 1)) - (neg ? QB'(0) : QB'(1));
    sat   = ovf_q[QB] || (mag > limit);
    clip  = sat ? limit : mag;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctl_q[QB].valid;
    end
    if (ctl_q[QB].degen) begin
      result <= '{volume: '0, degenerate: 1'b1, saturated: 1'b0};
    end else begin
      result.volume     <= neg ? -$signed(clip[VW-1:0]) : $signed(clip[VW-1:0]);
      result.degenerate <= 1'b0;
      result.saturated  <= sat;
    end
  end

endmodule

// ===== rtl/spin_polyhedron_volume_top.sv =====
// spin polyhedron volume: top level pipeline
// depends on spv_pkg, spv_tprod, spv_mul, spv_sqrt2, spv_div
//
// Usage: present the twelve Q16.16 spin components on in_item and raise start.
// A request is taken at each rising edge with start high and busy low; busy is
// high only while rst is asserted, so one request can enter every cycle.
// Each result appears on result for exactly one cycle with done high; the
// receiver cannot stall, so results simply stream out in request order.
// From the accepting edge to the edge that takes the result, a request passes
// the triple products, the two chained wide multiplies (one 32x32 partial
// product per stage), the square roots (one root bit per stage over a
// 300-bit radicand) and the rounded division and output register.
// Throughput is one request per cycle. Reset clears all valid bits; any
// request in flight at reset is dropped. A zero w123 gives volume 0 with
// degenerate set; an out of range volume is clipped with saturated set.
module spin_polyhedron_volume_top #(
  parameter int FRAC_BITS  = 16,
  parameter int COMP_WIDTH = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  spv_pkg::spv_in_t  in_item,
  output logic              done,
  output spv_pkg::spv_out_t result
);

  localparam int MW    = 3 * COMP_WIDTH + 1;
  localparam int SHIFT = 1 - FRAC_BITS + 2 * spv_pkg::GUARD_BITS;
  localparam int RW0   = 3 * MW + SHIFT;
  localparam int RW    = RW0 + (RW0 % 2);
  localparam int RTW   = RW / 2;

  logic [MW-1:0]     m1, m2, m3, n1, n2, n3, absw;
  spv_pkg::spv_ctl_t ctl_t;
  logic              req;

  logic              v1, v2, v3;
  logic [2*MW-1:0]   p12, q12;
  logic [3*MW:0]     sb1;
  logic [3*MW-1:0]   pp, qq;
  logic [MW:0]       sb2, sb3;
  logic [RTW-1:0]    ra, rb;
  spv_pkg::spv_ctl_t ctl_d;

  assign busy = rst;
  assign req  = start && !busy;

  spv_tprod #(.CW(COMP_WIDTH)) u_tprod (
    .clk, .rst, .req, .in_item,
    .m1, .m2, .m3, .n1, .n2, .n3, .absw, .ctl(ctl_t)
  );

  spv_mul #(.AW(MW), .BW(MW), .SBW(3 * MW + 1)) u_mul1 (
    .clk, .rst, .vin(ctl_t.valid),
    .a0(m1), .b0(m2), .a1(n1), .b1(n2),
    .sbin({m3, n3, absw, ctl_t.degen}),
    .vout(v1), .p0(p12), .p1(q12), .sbout(sb1)
  );

  spv_mul #(.AW(2 * MW), .BW(MW), .SBW(MW + 1)) u_mul2 (
    .clk, .rst, .vin(v1),
    .a0(p12), .b0(sb1[3*MW:2*MW+1]), .a1(q12), .b1(sb1[2*MW:MW+1]),
    .sbin(sb1[MW:0]),
    .vout(v2), .p0(pp), .p1(qq), .sbout(sb2)
  );

  spv_sqrt2 #(.RW(RW), .SBW(MW + 1)) u_sqrt (
    .clk, .rst, .vin(v2),
    .x0(RW'(pp) << SHIFT), .x1(RW'(qq) << SHIFT), .sbin(sb2),
    .vout(v3), .r0(ra), .r1(rb), .sbout(sb3)
  );

  assign ctl_d = '{valid: v3, degen: sb3[0]};

  spv_div #(.RTW(RTW), .MW(MW)) u_div (
    .clk, .rst,
    .ctl_in(ctl_d),
    .ra, .rb, .absw(sb3[MW:1]),
    .done, .result
  );

endmodule

// ===== rtl/spv_chk.sv =====
// port-level checks for the spin polyhedron volume top level
// depends on spv_pkg; bound to spin_polyhedron_volume_top
module spv_chk (
  input logic              clk,
  input logic              rst,
  input logic              busy,
  input logic              done,
  input spv_pkg::spv_out_t result
);

  a_rst_quiet: assert property (@(posedge clk) rst |=> !done)
    else $error("result strobe right after reset");

  a_busy_rst: assert property (@(posedge clk) !rst |-> !busy)
    else $error("busy outside reset");

  a_degen: assert property (@(posedge clk) disable iff (rst)
      done && result.degenerate |-> (result.volume == '0) && !result.saturated)
    else $error("degenerate result not zero");

  a_sat: assert property (@(posedge clk) disable iff (rst)
      done && result.saturated |->
        (result.volume == 32'sh7fffffff) || (result.volume == 32'sh80000000))
    else $error("saturated result not at a limit");

endmodule

bind spin_polyhedron_volume_top spv_chk u_spv_chk (
  .clk, .rst, .busy, .done, .result
);

// ===== verif/tb.sv =====
// testbench for spin_polyhedron_volume_top: directed and random spin sets
// scored against a wide-integer predictor; depends on spv_pkg and the rtl
`timescale 1ns / 100ps

typedef logic signed [399:0] wide_t;

class volume_scoreboard;
  spv_pkg::spv_out_t pending[$];
  int unsigned errors;
  int unsigned checked;
  int unsigned n_degen;
  int unsigned n_sat;

  function new();
    errors = 0;
    checked = 0;
    n_degen = 0;
    n_sat = 0;
  endfunction

  static function wide_t isqrt(wide_t n);
    wide_t res;
    wide_t bitv;
    res = 0;
    bitv = wide_t'(1) <<< 396;
    while (bitv > n) bitv = bitv >>> 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n = n - (res + bitv);
        res = (res >>> 1) + bitv;
      end else begin
        res = res >>> 1;
      end
      bitv = bitv >>> 2;
    end
    return res;
  endfunction

  static function wide_t triple(wide_t v[12], int i, int j, int k);
    wide_t ax, ay, az, bx, by, bz, cx, cy, cz;
    ax = v[3*i]; ay = v[3*i+1]; az = v[3*i+2];
    bx = v[3*j]; by = v[3*j+1]; bz = v[3*j+2];
    cx = v[3*k]; cy = v[3*k+1]; cz = v[3*k+2];
    return ax * (by * cz - bz * cy) + ay * (bz * cx - bx * cz) + az * (bx * cy - by * cx);
  endfunction

  static function wide_t wabs(wide_t a);
    return (a < 0) ? -a : a;
  endfunction

  static function spv_pkg::spv_out_t volume_of(spv_pkg::spv_in_t x);
    wide_t v[12];
    wide_t w, w234, w134, w124, p, q, ra, rb, dm, den, quo, lim;
    logic neg;
    spv_pkg::spv_out_t r;
    v[0] = wide_t'(x.s1_x); v[1] = wide_t'(x.s1_y); v[2] = wide_t'(x.s1_z);
    v[3] = wide_t'(x.s2_x); v[4] = wide_t'(x.s2_y); v[5] = wide_t'(x.s2_z);
    v[6] = wide_t'(x.s3_x); v[7] = wide_t'(x.s3_y); v[8] = wide_t'(x.s3_z);
    v[9] = wide_t'(x.s4_x); v[10] = wide_t'(x.s4_y); v[11] = wide_t'(x.s4_z);
    r = '0;
    w = triple(v, 0, 1, 2);
    if (w == 0) begin
      r.degenerate = 1'b1;
      return r;
    end
    w234 = triple(v, 1, 2, 3);
    w134 = triple(v, 0, 2, 3);
    w124 = triple(v, 0, 1, 3);
    p = wabs(w234) * wabs(w134) * wabs(w124);
    q = wabs(w234 + w) * wabs(w134 - w) * wabs(w124 + w);
    ra = isqrt(p <<< (1 - 16 + 2 * spv_pkg::GUARD_BITS));
    rb = isqrt(q <<< (1 - 16 + 2 * spv_pkg::GUARD_BITS));
    neg = ra < rb;
    dm = neg ? rb - ra : ra - rb;
    den = (wabs(w) * 3) <<< spv_pkg::GUARD_BITS;
    quo = (2 * dm + den) / (2 * den);
    if (quo == 0) neg = 1'b0;
    lim = (wide_t'(1) <<< 31) - (neg ? 0 : 1);
    if (quo > lim) begin
      quo = lim;
      r.saturated = 1'b1;
    end
    r.volume = neg ? -quo[31:0] : quo[31:0];
    return r;
  endfunction

  function void note_request(spv_pkg::spv_in_t x);
    pending.push_back(volume_of(x));
  endfunction

  function void check_result(spv_pkg::spv_out_t got);
    spv_pkg::spv_out_t exp_r;
    if (pending.size() == 0) begin
      errors++;
      if (errors <= 10) $display("unexpected result %h", got);
      return;
    end
    exp_r = pending.pop_front();
    checked++;
    if (exp_r.degenerate) n_degen++;
    if (exp_r.saturated) n_sat++;
    if (got.volume !== exp_r.volume || got.degenerate !== exp_r.degenerate ||
        got.saturated !== exp_r.saturated) begin
      errors++;
      if (errors <= 10)
        $display("mismatch: exp vol %h degen %b sat %b, got vol %h degen %b sat %b",
                 exp_r.volume, exp_r.degenerate, exp_r.saturated,
                 got.volume, got.degenerate, got.saturated);
    end
  endfunction
endclass

module tb;
  localparam int LIMIT = 400000;
  localparam int N_RANDOM = 1430;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic done;
  spv_pkg::spv_in_t in_item = '0;
  spv_pkg::spv_out_t result;
  volume_scoreboard sb = new();
  int unsigned cycles = 0;
  int unsigned n_sent = 0;

  spin_polyhedron_volume_top u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .in_item(in_item), .done(done), .result(result)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("tb failed");
      $finish;
    end
    if (!rst && start && !busy) sb.note_request(in_item);
    if (!rst && done) sb.check_result(result);
  end

  function automatic logic [31:0] rand_comp(int mode);
    case (mode)
      0: return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
      1: return $urandom;
      2: return $urandom_range(0, 32'h0200_0000) - 32'h0100_0000;
      default: return $urandom_range(0, 512) - 256;
    endcase
  endfunction

  function automatic spv_pkg::spv_in_t rand_item();
    spv_pkg::spv_in_t x;
    int mode;
    mode = $urandom_range(0, 3);
    x.s1_x = rand_comp(mode); x.s1_y = rand_comp(mode); x.s1_z = rand_comp(mode);
    x.s2_x = rand_comp(mode); x.s2_y = rand_comp(mode); x.s2_z = rand_comp(mode);
    x.s3_x = rand_comp(mode); x.s3_y = rand_comp(mode); x.s3_z = rand_comp(mode);
    x.s4_x = rand_comp(mode); x.s4_y = rand_comp(mode); x.s4_z = rand_comp(mode);
    if ($urandom_range(0, 9) == 0) begin
      // coplanar first three spins
      x.s3_x = x.s1_x; x.s3_y = x.s1_y; x.s3_z = x.s1_z;
    end
    return x;
  endfunction

  task automatic send_request(spv_pkg::spv_in_t x, bit allow_idle);
    while (allow_idle && $urandom_range(0, 99) < 23) begin
      @(negedge clk);
      start <= 1'b0;
    end
    @(negedge clk);
    in_item <= x;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    n_sent++;
  endtask

  function automatic spv_pkg::spv_in_t fill(logic [31:0] c);
    spv_pkg::spv_in_t x;
    x = {12{c}};
    return x;
  endfunction

  initial begin
    spv_pkg::spv_in_t x;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    send_request('0, 1'b0);
    send_request(fill(32'h7fff_ffff), 1'b0);
    send_request(fill(32'h8000_0000), 1'b0);
    send_request(fill(32'hffff_ffff), 1'b1);
    x = '0;
    x.s1_x = 32'h0001_0000; x.s2_y = 32'h0001_0000; x.s3_z = 32'h0001_0000;
    x.s4_x = 32'h0001_0000; x.s4_y = 32'h0001_0000; x.s4_z = 32'h0001_0000;
    send_request(x, 1'b1);
    x.s4_x = 32'hffff_0000; x.s4_z = 32'h0000_8000;
    send_request(x, 1'b1);
    x.s1_x = 32'h0000_0001; x.s2_y = 32'h0000_0001; x.s3_z = 32'h0000_0001;
    x.s4_x = 32'h7fff_ffff; x.s4_y = 32'h8000_0000; x.s4_z = 32'h7fff_ffff;
    send_request(x, 1'b1);
    x.s1_x = 32'h7fff_ffff; x.s2_y = 32'h8000_0000; x.s3_z = 32'h7fff_ffff;
    x.s4_x = 32'h0000_0001; x.s4_y = 32'h0000_0000; x.s4_z = 32'h0000_0001;
    send_request(x, 1'b0);
    x.s3_z = 32'h0; x.s3_x = 32'h7fff_ffff;
    send_request(x, 1'b1);
    x.s1_y = 32'h8000_0000; x.s2_x = 32'h7fff_ffff; x.s3_y = 32'h0000_0003;
    send_request(x, 1'b1);
    for (int i = 0; i < 10; i++) send_request(rand_item(), 1'b0);
    for (int i = 0; i < N_RANDOM; i++)
      send_request(rand_item(), !(i >= 300 && i < 700));
    @(negedge clk);
    start <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    $display("sent %0d spin sets, checked %0d results", n_sent, sb.checked);
    $display("degenerate %0d, saturated %0d, errors %0d", sb.n_degen, sb.n_sat, sb.errors);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
rtl/spv_pkg.sv
rtl/spv_tprod.sv
rtl/spv_mul.sv
rtl/spv_sqrt2.sv
rtl/spv_div.sv
rtl/spin_polyhedron_volume_top.sv
rtl/spv_chk.sv
verif/tb.sv
